// ===== hdl/csf_pkg.sv =====
// ----------------------------------------------------------------------------
// csf_pkg: shared types and constants of the comment strip filter
// Character codes, the result bundle passed from front to back, and sizes.
// ----------------------------------------------------------------------------
package csf_pkg;

  localparam int MAX_RES = 4;                 // results one input byte can cause
  localparam int CNT_W   = $clog2(MAX_RES + 1);
  localparam int IDX_W   = $clog2(MAX_RES);
  localparam int QDEPTH  = 4;                 // bundles held between front and back
  localparam int QAW     = $clog2(QDEPTH);

  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  typedef enum logic [0:0] {
    REG_STRIP = 1'b0,
    REG_FOLD  = 1'b1
  } cfg_reg_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] ch;
    logic [MAX_RES-1:0]      err;
    logic [CNT_W-1:0]        cnt;
  } bundle_t;

endpackage

// ===== hdl/csf_front.sv =====
// ----------------------------------------------------------------------------
// csf_front: byte classifier of the comment strip filter
// Tracks comment state per accepted byte and builds its bundle of kept bytes.
// ----------------------------------------------------------------------------
module csf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic                cfg_wdata,
  input  logic                acc,
  input  logic [7:0]          text_char,
  input  logic                end_of_text,
  output logic                bun_push,
  output csf_pkg::bundle_t    bun
);
  import csf_pkg::*;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_BLOCK  = 2'd1,
    MODE_DROP   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    POS_FRESH  = 2'd0,
    POS_SECOND = 2'd1,
    POS_LATER  = 2'd2
  } pos_t;

  typedef struct packed {
    mode_t mode;
    pos_t  pos;
    logic  raw;    // raw slash waiting for its follower
    logic  kept;   // kept slash waiting for a second kept slash
    logic  star;   // previous block byte was a star
    logic  trunc;  // rest of logical line is cut
  } st_t;

  typedef struct packed {
    st_t     st;
    bundle_t b;
  } work_t;

  localparam st_t ST_CLEAR = '{MODE_NORMAL, POS_FRESH, 1'b0, 1'b0, 1'b0, 1'b0};

  st_t   st_r;
  st_t   st_nxt;
  logic  strip_r;
  logic  fold_r;
  work_t w;

  function automatic work_t f_emit(work_t wi, logic [7:0] c, logic err, logic fold);
    logic [7:0] v;
    v = c;
    if (fold && c >= CH_UP_A && c <= CH_UP_Z) v = c + CASE_OFS;
    if (wi.b.cnt < CNT_W'(MAX_RES)) begin
      wi.b.ch[wi.b.cnt[IDX_W-1:0]]  = v;
      wi.b.err[wi.b.cnt[IDX_W-1:0]] = err;
      wi.b.cnt = wi.b.cnt + CNT_W'(1);
    end
    return wi;
  endfunction

  function automatic work_t f_kept_byte(work_t wi, logic [7:0] c, logic fold);
    logic done;
    done = 1'b0;
    if (!wi.st.trunc) begin
      if (wi.st.kept) begin
        wi.st.kept = 1'b0;
        if (c == CH_SLASH) begin
          wi.st.trunc = 1'b1;
          done = 1'b1;
        end else begin
          wi = f_emit(wi, CH_SLASH, 1'b0, fold);
        end
      end
      if (!done) begin
        if (c == CH_SLASH) wi.st.kept = 1'b1;
        else wi = f_emit(wi, c, 1'b0, fold);
      end
    end
    return wi;
  endfunction

  function automatic work_t f_end_line(work_t wi, logic fold);
    if (wi.st.raw) begin
      wi.st.raw = 1'b0;
      wi = f_kept_byte(wi, CH_SLASH, fold);
    end
    if (wi.st.kept && !wi.st.trunc) wi = f_emit(wi, CH_SLASH, 1'b0, fold);
    wi.st.kept  = 1'b0;
    wi.st.trunc = 1'b0;
    wi.st.pos   = POS_FRESH;
    wi = f_emit(wi, CH_NL, 1'b0, fold);
    return wi;
  endfunction

  function automatic work_t f_normal_byte(work_t wi, logic [7:0] c, logic fold);
    pos_t pos;
    logic done;
    pos  = wi.st.pos;
    done = 1'b0;
    if (c == CH_NL) begin
      wi = f_end_line(wi, fold);
    end else begin
      wi.st.pos = (pos == POS_FRESH) ? POS_SECOND : POS_LATER;
      if (wi.st.raw) begin
        wi.st.raw = 1'b0;
        if (c == CH_STAR) begin
          wi.st.mode = MODE_BLOCK;
          wi.st.star = 1'b0;
          done = 1'b1;
        end else if (c == CH_SLASH && pos == POS_SECOND) begin
          wi.st.mode = MODE_DROP;
          done = 1'b1;
        end else begin
          wi = f_kept_byte(wi, CH_SLASH, fold);
        end
      end
      if (!done) begin
        if (c == CH_SLASH) wi.st.raw = 1'b1;
        else wi = f_kept_byte(wi, c, fold);
      end
    end
    return wi;
  endfunction

  always_comb begin
    w.st = st_r;
    w.b  = '0;
    if (!strip_r) begin
      // pass through, keep only the line position
      w = f_emit(w, text_char, 1'b0, fold_r);
      w.st = ST_CLEAR;
      w.st.pos = (text_char == CH_NL) ? POS_FRESH : POS_LATER;
      if (end_of_text && text_char != CH_NL) w = f_emit(w, CH_NL, 1'b0, fold_r);
    end else begin
      case (w.st.mode)
        MODE_BLOCK: begin
          if (text_char == CH_SLASH && w.st.star) begin
            w.st.mode = MODE_NORMAL;
            w.st.star = 1'b0;
          end else begin
            w.st.star = (text_char == CH_STAR);
          end
        end
        MODE_DROP: begin
          if (text_char == CH_NL) begin
            w.st.mode = MODE_NORMAL;
            w.st.pos  = POS_FRESH;
          end
        end
        default: w = f_normal_byte(w, text_char, fold_r);
      endcase
      if (end_of_text) begin
        if (w.st.mode == MODE_BLOCK) w = f_emit(w, CH_NL, 1'b1, fold_r);
        else if (w.st.mode != MODE_DROP && text_char != CH_NL) w = f_end_line(w, fold_r);
      end
    end
    if (end_of_text) w.st = ST_CLEAR;
  end

  assign st_nxt   = acc ? w.st : st_r;
  assign bun      = w.b;
  assign bun_push = acc && (w.b.cnt != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_CLEAR;
      strip_r <= 1'b1;
      fold_r  <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we && cfg_index == REG_STRIP) strip_r <= cfg_wdata;
      if (cfg_we && cfg_index == REG_FOLD)  fold_r  <= cfg_wdata;
    end
  end

endmodule

// ===== hdl/csf_queue.sv =====
// ----------------------------------------------------------------------------
// csf_queue: bundle queue between classifier and serializer
// Small flop-based FIFO; the head entry is shown without a read delay.
// ----------------------------------------------------------------------------
module csf_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  csf_pkg::bundle_t push_data,
  output logic             full,
  input  logic             pop,
  output csf_pkg::bundle_t head,
  output logic             q_empty
);
  import csf_pkg::*;

  bundle_t          mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !q_empty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QAW'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QAW'(1);
      if (do_push && !do_pop)      cnt_r <= cnt_r + (QAW+1)'(1);
      else if (do_pop && !do_push) cnt_r <= cnt_r - (QAW+1)'(1);
    end
  end

endmodule

// ===== hdl/csf_back.sv =====
// ----------------------------------------------------------------------------
// csf_back: result serializer of the comment strip filter
// Unpacks one bundle at a time onto the result queue ports, one beat a cycle if popped.
// ----------------------------------------------------------------------------
module csf_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_empty,
  input  csf_pkg::bundle_t q_head,
  output logic             q_pop,
  output logic             out_empty,
  input  logic             out_pop,
  output logic [7:0]       out_char,
  output logic             out_last_of_run,
  output logic             out_open_block_error
);
  import csf_pkg::*;

  bundle_t            cur_r;
  logic [IDX_W-1:0]   idx_r;
  logic               valid_r;
  logic               take;
  logic               last;
  logic               finish;

  assign last   = ({1'b0, idx_r} == CNT_W'(cur_r.cnt - CNT_W'(1)));
  assign take   = valid_r && out_pop;
  // the slot is free after this cycle: no bundle is held, or its last beat is taken
  assign finish = !valid_r || (take && last);
  assign q_pop  = finish && !q_empty;

  assign out_empty            = !valid_r;
  assign out_char             = cur_r.ch[idx_r];
  assign out_open_block_error = cur_r.err[idx_r];
  assign out_last_of_run      = last;

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (finish) begin
      valid_r <= 1'b0;
    end else if (take) begin
      idx_r <= idx_r + IDX_W'(1);
    end
  end

endmodule

// ===== hdl/comment_strip_filter.sv =====
// ----------------------------------------------------------------------------
// comment_strip_filter: streaming C-style comment remover
// Top level: classifier, bundle queue and result serializer.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive in_text_char / in_end_of_text with in_push; a beat is
//   taken at a clock edge with in_push high and in_full low. One byte can be
//   taken every cycle while the internal queue of four bundles has room.
//   Result queue: while out_empty is low the oldest kept byte sits on
//   out_char, out_last_of_run and out_open_block_error; out_pop takes it.
//   One result leaves per cycle while out_pop is high; a byte that expands
//   into k results holds the serializer until all k leave, and a byte with
//   no result never enters the queue. A result is registered in the bundle
//   queue, then in the serializer. If the receiver stalls, the queue fills;
//   in_full rises at four bundles. The classifier advances on taken bytes only.
//   Configuration: cfg_we with cfg_index 0 (strip) or 1 (fold lower case);
//   write only while the block is idle.
//   Reset (rst_n low, synchronous): stripping on, folding off, queue empty.
// ----------------------------------------------------------------------------
module comment_strip_filter (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic       cfg_wdata,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_text_char,
  input  logic       in_end_of_text,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char,
  output logic       out_last_of_run,
  output logic       out_open_block_error
);
  import csf_pkg::*;

  logic    acc;
  logic    bun_push;
  bundle_t bun;
  logic    q_full;
  logic    q_pop;
  logic    q_empty;
  bundle_t q_head;

  assign acc     = in_push && !q_full;
  assign in_full = q_full;

  csf_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .text_char   (in_text_char),
    .end_of_text (in_end_of_text),
    .bun_push    (bun_push),
    .bun         (bun)
  );

  csf_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (bun_push),
    .push_data (bun),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .q_empty   (q_empty)
  );

  csf_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_head               (q_head),
    .q_pop                (q_pop),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_char             (out_char),
    .out_last_of_run      (out_last_of_run),
    .out_open_block_error (out_open_block_error)
  );

endmodule

// ===== hdl/csf_checker.sv =====
// ----------------------------------------------------------------------------
// csf_checker: port-level checks of the comment strip filter
// Watches the top-level ports only; bound to every filter instance.
// ----------------------------------------------------------------------------
module csf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_we,
  input logic       cfg_index,
  input logic       cfg_wdata,
  input logic       in_push,
  input logic       in_full,
  input logic [7:0] in_text_char,
  input logic       in_end_of_text,
  input logic       out_empty,
  input logic       out_pop,
  input logic [7:0] out_char,
  input logic       out_last_of_run,
  input logic       out_open_block_error
);
  import csf_pkg::*;

  // nothing waits right after reset
  a_empty_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> out_empty)
    else $error("result present right after reset");

  // the error flag only rides on the closing newline
  a_err_is_newline: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_open_block_error) |-> (out_char == CH_NL))
    else $error("open block error on a byte other than newline");

  // the error newline is the only, and so the last, result of its byte
  a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_open_block_error) |-> out_last_of_run)
    else $error("open block error not on last result of its byte");

  // a stalled beat holds
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_char)
                                  && $stable(out_last_of_run)))
    else $error("stalled result changed");

endmodule

bind comment_strip_filter csf_checker u_csf_checker (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for comment_strip_filter
// Streams short C-like texts (line comments, block comments spanning lines,
// stray slashes and stars, arbitrary bytes) through the filter. The expected
// kept bytes come from a cycle-free scanner model in this file. Expected
// bytes are queued when a text byte is taken and compared in order as kept
// bytes leave. The sender works in bursts with gaps and the receiver stalls
// at random. Strip and fold settings change between phases while idle.
// ----------------------------------------------------------------------------
module tb;
  import csf_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [1:0] {SCAN_NORMAL, SCAN_BLOCK, SCAN_DROP} scan_mode_t;
  typedef enum logic [1:0] {POS_FRESH, POS_SECOND, POS_LATER} line_pos_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_beat_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       err;
  } kept_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic       cfg_index = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_push = 1'b0;
  logic       in_full;
  logic [7:0] in_text_char = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_empty;
  logic       out_pop = 1'b0;
  logic [7:0] out_char;
  logic       out_last_of_run;
  logic       out_open_block_error;

  comment_strip_filter uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_text_char        (in_text_char),
    .in_end_of_text      (in_end_of_text),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_char            (out_char),
    .out_last_of_run     (out_last_of_run),
    .out_open_block_error(out_open_block_error)
  );

  always #1 clk = ~clk;

  // scanner model state and settings
  logic       strip_en = 1'b1;
  logic       fold_en = 1'b0;
  scan_mode_t scan_mode = SCAN_NORMAL;
  line_pos_t  line_pos = POS_FRESH;
  logic       raw_slash = 1'b0;
  logic       kept_slash = 1'b0;
  logic       star_prev = 1'b0;
  logic       cut_line = 1'b0;

  kept_beat_t run_buf [MAX_RES];
  int         run_n;

  text_beat_t pend_q [$];
  kept_beat_t kept_q [$];

  int  n_queued = 0;
  int  n_bytes = 0;
  int  n_kept = 0;
  int  n_err_seen = 0;
  int  n_fail = 0;
  int  cycles = 0;
  int  gap_left = 0;
  int  burst_left = 0;
  int  stall_left = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;

  task automatic put_char(input logic [7:0] c, input logic e);
    if (run_n >= MAX_RES) return;
    if (fold_en && c >= CH_UP_A && c <= CH_UP_Z) c = c + CASE_OFS;
    run_buf[run_n] = kept_beat_t'{ch: c, last: 1'b0, err: e};
    run_n++;
  endtask

  task automatic clear_scan();
    scan_mode = SCAN_NORMAL;
    line_pos = POS_FRESH;
    raw_slash = 1'b0;
    kept_slash = 1'b0;
    star_prev = 1'b0;
    cut_line = 1'b0;
  endtask

  // bytes that survive raw comment detection; a kept // cuts the line
  task automatic take_kept(input logic [7:0] c);
    if (cut_line) return;
    if (kept_slash) begin
      kept_slash = 1'b0;
      if (c == CH_SLASH) begin
        cut_line = 1'b1;
        return;
      end
      put_char(CH_SLASH, 1'b0);
    end
    if (c == CH_SLASH) kept_slash = 1'b1;
    else put_char(c, 1'b0);
  endtask

  task automatic close_line();
    if (raw_slash) begin
      raw_slash = 1'b0;
      take_kept(CH_SLASH);
    end
    if (kept_slash && !cut_line) put_char(CH_SLASH, 1'b0);
    kept_slash = 1'b0;
    cut_line = 1'b0;
    line_pos = POS_FRESH;
    put_char(CH_NL, 1'b0);
  endtask

  task automatic scan_text(input logic [7:0] c);
    line_pos_t p;
    p = line_pos;
    if (c == CH_NL) begin
      close_line();
      return;
    end
    line_pos = (p == POS_FRESH) ? POS_SECOND : POS_LATER;
    if (raw_slash) begin
      raw_slash = 1'b0;
      if (c == CH_STAR) begin
        scan_mode = SCAN_BLOCK;
        star_prev = 1'b0;
        return;
      end
      if (c == CH_SLASH && p == POS_SECOND) begin
        scan_mode = SCAN_DROP;
        return;
      end
      take_kept(CH_SLASH);
    end
    if (c == CH_SLASH) raw_slash = 1'b1;
    else take_kept(c);
  endtask

  // work out the kept bytes one text byte causes and queue them
  task automatic predict_kept(input logic [7:0] c, input logic eot);
    run_n = 0;
    if (!strip_en) begin
      put_char(c, 1'b0);
      clear_scan();
      line_pos = (c == CH_NL) ? POS_FRESH : POS_LATER;
      if (eot && c != CH_NL) put_char(CH_NL, 1'b0);
    end else begin
      case (scan_mode)
        SCAN_BLOCK: begin
          if (c == CH_SLASH && star_prev) begin
            scan_mode = SCAN_NORMAL;
            star_prev = 1'b0;
          end else begin
            star_prev = (c == CH_STAR);
          end
        end
        SCAN_DROP: begin
          if (c == CH_NL) begin
            scan_mode = SCAN_NORMAL;
            line_pos = POS_FRESH;
          end
        end
        default: scan_text(c);
      endcase
      if (eot) begin
        if (scan_mode == SCAN_BLOCK) put_char(CH_NL, 1'b1);
        else if (scan_mode != SCAN_DROP && c != CH_NL) close_line();
      end
    end
    if (eot) clear_scan();
    for (int k = 0; k < run_n; k++) begin
      if (k == run_n - 1) run_buf[k].last = 1'b1;
      kept_q.push_back(run_buf[k]);
    end
  endtask

  task automatic add_bytes(input string s, input logic end_here);
    for (int i = 0; i < s.len(); i++) begin
      pend_q.push_back(text_beat_t'{ch: s[i], eot: end_here && (i == s.len() - 1)});
      n_queued++;
    end
  endtask

  // one random text: letters, spaces, slashes, stars, newlines, some arbitrary bytes
  task automatic add_text(input int len);
    int         n;
    int         r;
    logic [7:0] c0;
    logic [7:0] c1;
    logic       two;
    n = 0;
    while (n < len) begin
      r = $urandom_range(0, 99);
      two = 1'b0;
      c1 = CH_SLASH;
      if (r < 28) begin
        c0 = CH_UP_A + ($urandom_range(0, 1) ? CASE_OFS : 8'h00) + 8'($urandom_range(0, 25));
      end else if (r < 38) begin
        c0 = 8'h20;
      end else if (r < 46) begin
        c0 = CH_SLASH;
      end else if (r < 52) begin
        c0 = CH_STAR;
      end else if (r < 60) begin
        c0 = CH_SLASH;
        c1 = CH_STAR;
        two = 1'b1;
      end else if (r < 70) begin
        c0 = CH_STAR;
        two = 1'b1;
      end else if (r < 77) begin
        c0 = CH_SLASH;
        two = 1'b1;
      end else if (r < 91) begin
        c0 = CH_NL;
      end else begin
        c0 = 8'($urandom_range(0, 255));
      end
      pend_q.push_back(text_beat_t'{ch: c0, eot: 1'b0});
      n++;
      if (two) begin
        pend_q.push_back(text_beat_t'{ch: c1, eot: 1'b0});
        n++;
      end
    end
    if ($urandom_range(0, 2) == 0) begin
      pend_q.push_back(text_beat_t'{ch: CH_NL, eot: 1'b0});
      n++;
    end
    pend_q[pend_q.size() - 1].eot = 1'b1;
    n_queued += n;
  endtask

  task automatic add_random(input int target);
    int goal;
    goal = n_queued + target;
    while (n_queued < goal) add_text($urandom_range(1, 30));
  endtask

  // hold until the sender is empty and every kept byte has arrived
  task automatic wait_idle();
    do @(negedge clk);
    while (pend_q.size() != 0 || in_push || kept_q.size() != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_STRIP) strip_en = val;
    else fold_en = val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // sender: bursts of random length, random gaps between them
  always @(posedge clk) begin
    text_beat_t nb;
    logic       np;
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      np = in_push;
      nb = text_beat_t'{ch: in_text_char, eot: in_end_of_text};
      if (in_push && !in_full) begin
        predict_kept(in_text_char, in_end_of_text);
        n_bytes++;
        np = 1'b0;
      end
      if (!np) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pend_q.size() > 0) begin
          nb = pend_q.pop_front();
          np = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 12);
            gap_left = gaps_on ? $urandom_range(0, 5) : 0;
          end
        end
      end
      in_push <= np;
      in_text_char <= nb.ch;
      in_end_of_text <= nb.eot;
    end
  end

  // receiver: check each popped beat, stall in random runs
  always @(posedge clk) begin
    kept_beat_t w;
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        n_kept++;
        if (out_open_block_error) n_err_seen++;
        if (kept_q.size() == 0) begin
          $display("%0t: unexpected beat char=%02h last=%0b err=%0b", $time,
                   out_char, out_last_of_run, out_open_block_error);
          n_fail++;
        end else begin
          w = kept_q.pop_front();
          if (w !== kept_beat_t'{ch: out_char, last: out_last_of_run,
                                 err: out_open_block_error}) begin
            $display("%0t: mismatch expected char=%02h last=%0b err=%0b, got char=%02h last=%0b err=%0b",
                     $time, w.ch, w.last, w.err, out_char, out_last_of_run,
                     out_open_block_error);
            n_fail++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (stalls_on && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("comment_strip_filter regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // line comment, block over a newline with slash-star-slash, kept slash
    // pair around a block, unclosed block at text end, extreme bytes
    add_bytes("//\n", 1'b0);
    add_bytes("/*/\n*/", 1'b0);
    add_bytes("x//**//y\n", 1'b0);
    add_bytes("Q/*", 1'b1);
    pend_q.push_back(text_beat_t'{ch: 8'h00, eot: 1'b0});
    pend_q.push_back(text_beat_t'{ch: 8'hff, eot: 1'b1});
    n_queued += 2;
    add_random(50);
    wait_idle();

    write_reg(REG_FOLD, 1'b1);
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    add_random(45);
    wait_idle();

    write_reg(REG_STRIP, 1'b0);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    add_random(35);
    wait_idle();

    write_reg(REG_FOLD, 1'b0);
    add_random(25);
    wait_idle();

    write_reg(REG_STRIP, 1'b1);
    add_random(50);
    wait_idle();
    repeat (10) @(posedge clk);

    $display("sent %0d text bytes over five strip/fold settings", n_bytes);
    $display("checked %0d kept bytes, %0d of them unclosed-block flags", n_kept, n_err_seen);
    if (n_fail == 0 && kept_q.size() == 0) begin
      $display("comment_strip_filter regression: pass");
    end else begin
      $display("comment_strip_filter regression: fail");
    end
    $finish;
  end

endmodule
